// File: sv/keypad_rfid_lock_controller_assert.svh
// Assertion macros for the keypad and card lock controller.
// Used by the port checker; needs nothing else.
`ifndef KEYPAD_RFID_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_RFID_LOCK_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define KRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock controller check failed");

// next-cycle implication
`define KRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock controller check failed");

`endif

// File: sv/krlc_pkg.sv
// Shared types and constants of the keypad and card lock controller.
// No dependencies.
package krlc_pkg;

    typedef enum logic [1:0] {
        MODE_SELECT = 2'd0,
        MODE_KEYPAD = 2'd1,
        MODE_CARD   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SUB_NORMAL = 2'd0,
        SUB_OLD    = 2'd1,
        SUB_NEW    = 2'd2
    } t_sub;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_KEYPAD    = 4'd1,
        EV_CARD      = 4'd2,
        EV_DIGIT     = 4'd3,
        EV_OVERFLOW  = 4'd4,
        EV_ERASE     = 4'd5,
        EV_GRANT     = 4'd6,
        EV_DENY      = 4'd7,
        EV_LOCKOUT   = 4'd8,
        EV_OLDOK     = 4'd9,
        EV_OLDBAD    = 4'd10,
        EV_CHANGED   = 4'd11,
        EV_CHANGEREQ = 4'd12,
        EV_IGNORED   = 4'd13,
        EV_SELECT    = 4'd14,
        EV_UNLOCKED  = 4'd15
    } t_event;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_CARD = 2'd2;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_B         = 4'd11;
    localparam logic [3:0] KEY_C         = 4'd12;
    localparam logic [3:0] KEY_D         = 4'd13;
    localparam logic [3:0] KEY_STAR      = 4'd14;
    localparam logic [3:0] KEY_HASH      = 4'd15;

    localparam logic [1:0] CFG_CARD_A     = 2'd0;
    localparam logic [1:0] CFG_CARD_B     = 2'd1;
    localparam logic [1:0] CFG_FAIL_LIMIT = 2'd2;
    localparam logic [1:0] CFG_LOCK_TICKS = 2'd3;

    localparam logic [63:0] CARD_A_RESET     = 64'h75DA6F06C6;
    localparam logic [63:0] CARD_B_RESET     = 64'hF19A380654;
    localparam logic [2:0]  FAIL_LIMIT_RESET = 3'd3;
    localparam logic [15:0] LOCK_TICKS_RESET = 16'd10000;
    localparam int          PWD_RESET_LEN    = 6;

    localparam logic [2:0]  FAIL_MAX    = 3'd7;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic commit;
    } t_store_ctl;

endpackage

// File: sv/krlc_if.sv
// Valid/ready channel interfaces of the lock controller.
// Depends on nothing; card width is set by the instantiating level.
interface krlc_in_if #(
    parameter int CARD_W = 40
) ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [3:0]        key_code;
    logic [CARD_W-1:0] card_id;

    modport source (output valid, kind, key_code, card_id, input ready);
    modport sink   (input valid, kind, key_code, card_id, output ready);
endinterface

interface krlc_out_if ();
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic       access_grant;
    logic       locked_now;
    logic [1:0] current_mode;
    logic [3:0] entry_count;

    modport source (output valid, event_code, access_grant, locked_now, current_mode,
                    entry_count, input ready);
    modport sink   (input valid, event_code, access_grant, locked_now, current_mode,
                    entry_count, output ready);
endinterface

// File: sv/krlc_store.sv
// Entry buffer and stored password with the full-width match compare.
// Depends on krlc_pkg.
module krlc_store #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  krlc_pkg::t_store_ctl               i_ctl,
    input  logic [3:0]                         i_digit,
    output logic [$clog2(MAX_DIGITS+1)-1:0]    o_len,
    output logic [$clog2(MAX_DIGITS+1)-1:0]    o_len_nx,
    output logic                               o_full,
    output logic                               o_match
);
    localparam int LenW    = $clog2(MAX_DIGITS + 1);
    localparam int PwdLen0 = (MAX_DIGITS < krlc_pkg::PWD_RESET_LEN) ?
                             MAX_DIGITS : krlc_pkg::PWD_RESET_LEN;

    logic [3:0]      r_ent [MAX_DIGITS];
    logic [3:0]      r_pwd [MAX_DIGITS];
    logic [LenW-1:0] r_len;
    logic [LenW-1:0] r_pwd_len;
    logic [LenW-1:0] n_len;

    always_comb begin
        n_len = r_len;
        if (i_ctl.clear) begin
            n_len = '0;
        end else if (i_ctl.push) begin
            n_len = r_len + LenW'(1);
        end else if (i_ctl.pop) begin
            n_len = r_len - LenW'(1);
        end
    end

    always_comb begin
        o_match = (r_len == r_pwd_len);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if ((LenW'(i) < r_len) && (r_ent[i] != r_pwd[i])) begin
                o_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i_ctl.push && (r_len == LenW'(i))) begin
                r_ent[i] <= i_digit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pwd_len <= LenW'(PwdLen0);
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_pwd[i] <= (i < PwdLen0) ? 4'(i + 1) : 4'd0;
            end
        end else begin
            r_len <= n_len;
            if (i_ctl.commit) begin
                r_pwd_len <= r_len;
                r_pwd     <= r_ent;
            end
        end
    end

    assign o_len    = r_len;
    assign o_len_nx = n_len;
    assign o_full   = (r_len >= LenW'(MAX_DIGITS));
endmodule

// File: sv/keypad_rfid_lock_controller.sv
// Top level of the keypad and card lock controller: input register, mode
// control, failure/lockout logic and result register. Depends on krlc_pkg,
// krlc_if and krlc_store.
//
// Usage:
//   i_in carries one transaction per key press, card read or millisecond tick;
//   o_out returns exactly one result transaction per input transaction.
//   An accepted transaction is held in the input register; once the result
//   register is free, an edge evaluates it against the mode, entry and password
//   state and loads the result register, which raises o_out.valid.
//   Throughput is one transaction per cycle while o_out.ready stays high; the
//   single evaluation stage between the two registers sets this.
//   When o_out.ready is low the result register holds, the input register
//   still takes one more transaction, and i_in.ready then drops until the
//   result is taken.
//   Synchronous reset restores the default password, cards, limits and
//   select mode at once; no clearing pass is needed.
//   Configuration writes (i_cfg_we) take effect on the next edge; the user must
//   make them only while no transaction is in flight; the block does not enforce it.
module keypad_rfid_lock_controller #(
    parameter int MAX_DIGITS = 10,
    parameter int CARD_BYTES = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    krlc_in_if.sink                   i_in,
    krlc_out_if.source                o_out,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [8*CARD_BYTES-1:0]   i_cfg_data
);
    localparam int CardW = 8 * CARD_BYTES;
    localparam int LenW  = $clog2(MAX_DIGITS + 1);

    logic             r_in_vld;
    logic [1:0]       r_kind;
    logic [3:0]       r_key;
    logic [CardW-1:0] r_card;

    logic [CardW-1:0] r_card_a;
    logic [CardW-1:0] r_card_b;
    logic [2:0]       r_fail_lim;
    logic [15:0]      r_lock_ticks;

    krlc_pkg::t_mode  r_mode, n_mode;
    krlc_pkg::t_sub   r_sub, n_sub;
    logic [2:0]       r_fail, n_fail;
    logic             r_locked, n_locked;
    logic [15:0]      r_elapsed, n_elapsed;

    logic             r_out_vld;
    krlc_pkg::t_event r_ev;
    logic             r_grant;
    logic             r_out_locked;
    krlc_pkg::t_mode  r_out_mode;
    logic [3:0]       r_out_cnt;

    krlc_pkg::t_event     ev;
    logic                 grant;
    krlc_pkg::t_store_ctl st_ctl;
    logic [LenW-1:0]      ent_len, ent_len_nx;
    logic                 ent_full, ent_match;
    logic                 out_free, fire;
    logic [2:0]           fail_inc;
    logic [15:0]          elapsed_inc;
    logic                 card_ok;

    assign out_free    = !r_out_vld || o_out.ready;
    assign fire        = r_in_vld && out_free;
    assign i_in.ready  = !r_in_vld || out_free;
    assign fail_inc    = (r_fail < krlc_pkg::FAIL_MAX) ? r_fail + 3'd1 : r_fail;
    assign elapsed_inc = (r_elapsed < krlc_pkg::ELAPSED_MAX) ? r_elapsed + 16'd1
                                                               : r_elapsed;
    assign card_ok     = (r_card == r_card_a) || (r_card == r_card_b);

    krlc_store #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (st_ctl),
        .i_digit  (r_key),
        .o_len    (ent_len),
        .o_len_nx (ent_len_nx),
        .o_full   (ent_full),
        .o_match  (ent_match)
    );

    always_comb begin
        n_mode    = r_mode;
        n_sub     = r_sub;
        n_fail    = r_fail;
        n_locked  = r_locked;
        n_elapsed = r_elapsed;
        ev        = krlc_pkg::EV_NONE;
        grant     = 1'b0;
        st_ctl    = '0;
        if (fire) begin
            case (r_kind)
                krlc_pkg::KIND_TICK: begin
                    if (r_locked) begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_lock_ticks) begin
                            n_locked = 1'b0;
                            n_fail   = '0;
                            n_mode   = krlc_pkg::MODE_SELECT;
                            ev       = krlc_pkg::EV_UNLOCKED;
                        end
                    end
                end
                krlc_pkg::KIND_KEY: begin
                    if (!r_locked) begin
                        if (r_mode == krlc_pkg::MODE_SELECT) begin
                            if (r_key == krlc_pkg::KEY_A) begin
                                n_mode = krlc_pkg::MODE_KEYPAD;
                                ev     = krlc_pkg::EV_KEYPAD;
                            end else if (r_key == krlc_pkg::KEY_B) begin
                                n_mode = krlc_pkg::MODE_CARD;
                                ev     = krlc_pkg::EV_CARD;
                            end
                        end else if (r_key == krlc_pkg::KEY_D) begin
                            n_mode = krlc_pkg::MODE_SELECT;
                            ev     = krlc_pkg::EV_SELECT;
                        end else if (r_mode == krlc_pkg::MODE_KEYPAD) begin
                            if (r_key <= krlc_pkg::KEY_DIGIT_MAX) begin
                                if (!ent_full) begin
                                    st_ctl.push = 1'b1;
                                    ev          = krlc_pkg::EV_DIGIT;
                                end else begin
                                    st_ctl.clear = 1'b1;
                                    ev           = krlc_pkg::EV_OVERFLOW;
                                end
                            end else if (r_key == krlc_pkg::KEY_HASH) begin
                                st_ctl.clear = 1'b1;
                                case (r_sub)
                                    krlc_pkg::SUB_OLD: begin
                                        n_sub = ent_match ? krlc_pkg::SUB_NEW
                                                          : krlc_pkg::SUB_NORMAL;
                                        ev    = ent_match ? krlc_pkg::EV_OLDOK
                                                          : krlc_pkg::EV_OLDBAD;
                                    end
                                    krlc_pkg::SUB_NEW: begin
                                        st_ctl.commit = 1'b1;
                                        n_sub         = krlc_pkg::SUB_NORMAL;
                                        ev            = krlc_pkg::EV_CHANGED;
                                    end
                                    default: begin
                                        if (ent_match) begin
                                            grant = 1'b1;
                                            ev    = krlc_pkg::EV_GRANT;
                                        end else begin
                                            n_fail = fail_inc;
                                            if (fail_inc >= r_fail_lim) begin
                                                n_locked  = 1'b1;
                                                n_elapsed = '0;
                                                ev        = krlc_pkg::EV_LOCKOUT;
                                            end else begin
                                                ev = krlc_pkg::EV_DENY;
                                            end
                                        end
                                    end
                                endcase
                            end else if (r_key == krlc_pkg::KEY_STAR) begin
                                if (ent_len != '0) begin
                                    st_ctl.pop = 1'b1;
                                    ev         = krlc_pkg::EV_ERASE;
                                end
                            end else if (r_key == krlc_pkg::KEY_C) begin
                                n_sub        = krlc_pkg::SUB_OLD;
                                st_ctl.clear = 1'b1;
                                ev           = krlc_pkg::EV_CHANGEREQ;
                            end else begin
                                ev = krlc_pkg::EV_IGNORED;
                            end
                        end
                    end
                end
                krlc_pkg::KIND_CARD: begin
                    if (!r_locked && (r_mode == krlc_pkg::MODE_CARD)) begin
                        if (card_ok) begin
                            grant = 1'b1;
                            ev    = krlc_pkg::EV_GRANT;
                        end else begin
                            n_fail = fail_inc;
                            if (fail_inc >= r_fail_lim) begin
                                n_locked  = 1'b1;
                                n_elapsed = '0;
                                ev        = krlc_pkg::EV_LOCKOUT;
                            end else begin
                                ev = krlc_pkg::EV_DENY;
                            end
                        end
                    end
                end
                default: begin
                    ev = krlc_pkg::EV_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= krlc_pkg::MODE_SELECT;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub     <= krlc_pkg::SUB_NORMAL;
            r_fail    <= '0;
            r_locked  <= 1'b0;
            r_elapsed <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_sub     <= n_sub;
            r_fail    <= n_fail;
            r_locked  <= n_locked;
            r_elapsed <= n_elapsed;
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_a     <= CardW'(krlc_pkg::CARD_A_RESET);
            r_card_b     <= CardW'(krlc_pkg::CARD_B_RESET);
            r_fail_lim   <= krlc_pkg::FAIL_LIMIT_RESET;
            r_lock_ticks <= krlc_pkg::LOCK_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                krlc_pkg::CFG_CARD_A:     r_card_a     <= i_cfg_data;
                krlc_pkg::CFG_CARD_B:     r_card_b     <= i_cfg_data;
                krlc_pkg::CFG_FAIL_LIMIT: r_fail_lim   <= i_cfg_data[2:0];
                krlc_pkg::CFG_LOCK_TICKS: r_lock_ticks <= i_cfg_data[15:0];
                default: begin
                    r_fail_lim <= r_fail_lim;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_key  <= i_in.key_code;
            r_card <= i_in.card_id[CardW-1:0];
        end
        if (fire) begin
            r_ev         <= ev;
            r_grant      <= grant;
            r_out_locked <= n_locked;
            r_out_mode   <= n_mode;
            r_out_cnt    <= 4'(ent_len_nx);
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.event_code   = r_ev;
    assign o_out.access_grant = r_grant;
    assign o_out.locked_now   = r_out_locked;
    assign o_out.current_mode = r_out_mode;
    assign o_out.entry_count  = r_out_cnt;
endmodule

// File: sv/krlc_checker.sv
// Port-level checker for the lock controller, bound to the top level.
// Depends on krlc_pkg and keypad_rfid_lock_controller_assert.svh.
`include "keypad_rfid_lock_controller_assert.svh"

module krlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_event_code,
    input logic       i_grant,
    input logic       i_locked,
    input logic [1:0] i_mode
);
    `KRLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_event_code) && $stable(i_mode))
    `KRLC_ASSERT_NOW(a_lockout_locks, i_clk, i_rst_n,
        i_out_valid && (i_event_code == krlc_pkg::EV_LOCKOUT), i_locked && !i_grant)
    `KRLC_ASSERT_NOW(a_unlock_select, i_clk, i_rst_n,
        i_out_valid && (i_event_code == krlc_pkg::EV_UNLOCKED),
        !i_locked && (i_mode == krlc_pkg::MODE_SELECT))
    `KRLC_ASSERT_NOW(a_grant_event, i_clk, i_rst_n, i_out_valid && i_grant,
        (i_event_code == krlc_pkg::EV_GRANT) && !i_locked)
endmodule

bind keypad_rfid_lock_controller krlc_checker u_krlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_code (o_out.event_code),
    .i_grant      (o_out.access_grant),
    .i_locked     (o_out.locked_now),
    .i_mode       (o_out.current_mode)
);

// File: verif/tb_top.sv
// Self-checking testbench for keypad_rfid_lock_controller: drives key, card and tick
// transactions with random gaps and back-pressure, and compares every result with a
// cycle-free model of the lock kept in a scoreboard class. Needs krlc_pkg and krlc_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CARD_W      = 40;
    localparam int         MAX_ENTRY   = 10;
    localparam int         ITEM_TARGET = 1100;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    class lock_tracker;
        logic [CARD_W-1:0] card_a;
        logic [CARD_W-1:0] card_b;
        logic [2:0]        fail_limit;
        logic [15:0]       lock_ticks;
        logic [3:0]        pwd [MAX_ENTRY];
        int                pwd_len;
        logic [3:0]        entry [MAX_ENTRY];
        int                entry_len;
        krlc_pkg::t_mode   mode;
        krlc_pkg::t_sub    sub;
        logic [2:0]        fail_cnt;
        bit                locked;
        logic [15:0]       elapsed;
        int                errors;

        typedef struct packed {
            krlc_pkg::t_event ev;
            logic             grant;
            logic             lock;
            krlc_pkg::t_mode  mode;
            logic [3:0]       count;
        } t_outcome;

        t_outcome pending_outcomes[$];

        function new();
            card_a     = krlc_pkg::CARD_A_RESET[CARD_W-1:0];
            card_b     = krlc_pkg::CARD_B_RESET[CARD_W-1:0];
            fail_limit = krlc_pkg::FAIL_LIMIT_RESET;
            lock_ticks = krlc_pkg::LOCK_TICKS_RESET;
            for (int i = 0; i < MAX_ENTRY; i++) begin
                pwd[i]   = (i < krlc_pkg::PWD_RESET_LEN) ? 4'(i + 1) : 4'd0;
                entry[i] = 4'd0;
            end
            pwd_len   = krlc_pkg::PWD_RESET_LEN;
            entry_len = 0;
            mode      = krlc_pkg::MODE_SELECT;
            sub       = krlc_pkg::SUB_NORMAL;
            fail_cnt  = 3'd0;
            locked    = 1'b0;
            elapsed   = 16'd0;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CARD_W-1:0] val);
            case (idx)
                krlc_pkg::CFG_CARD_A:     card_a = val;
                krlc_pkg::CFG_CARD_B:     card_b = val;
                krlc_pkg::CFG_FAIL_LIMIT: fail_limit = val[2:0];
                krlc_pkg::CFG_LOCK_TICKS: lock_ticks = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function bit entry_ok();
            if (entry_len != pwd_len)
                return 1'b0;
            for (int i = 0; i < entry_len; i++)
                if (entry[i] != pwd[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function krlc_pkg::t_event fail_event();
            if (fail_cnt < krlc_pkg::FAIL_MAX)
                fail_cnt++;
            if (fail_cnt >= fail_limit) begin
                locked  = 1'b1;
                elapsed = 16'd0;
                return krlc_pkg::EV_LOCKOUT;
            end
            return krlc_pkg::EV_DENY;
        endfunction

        function void note_transaction(logic [1:0] kind, logic [3:0] key,
                                       logic [CARD_W-1:0] card);
            krlc_pkg::t_event ev;
            logic             grant;
            bit               ok;
            t_outcome         o;
            ev    = krlc_pkg::EV_NONE;
            grant = 1'b0;
            if (kind == krlc_pkg::KIND_TICK) begin
                if (locked) begin
                    if (elapsed < krlc_pkg::ELAPSED_MAX)
                        elapsed++;
                    if (elapsed >= lock_ticks) begin
                        locked   = 1'b0;
                        fail_cnt = 3'd0;
                        mode     = krlc_pkg::MODE_SELECT;
                        ev       = krlc_pkg::EV_UNLOCKED;
                    end
                end
            end else if (locked) begin
                ev = krlc_pkg::EV_NONE;
            end else if (kind == krlc_pkg::KIND_KEY) begin
                if (mode == krlc_pkg::MODE_SELECT) begin
                    if (key == krlc_pkg::KEY_A) begin
                        mode = krlc_pkg::MODE_KEYPAD;
                        ev   = krlc_pkg::EV_KEYPAD;
                    end else if (key == krlc_pkg::KEY_B) begin
                        mode = krlc_pkg::MODE_CARD;
                        ev   = krlc_pkg::EV_CARD;
                    end
                end else if (key == krlc_pkg::KEY_D) begin
                    mode = krlc_pkg::MODE_SELECT;
                    ev   = krlc_pkg::EV_SELECT;
                end else if (mode == krlc_pkg::MODE_KEYPAD) begin
                    if (key <= krlc_pkg::KEY_DIGIT_MAX) begin
                        if (entry_len < MAX_ENTRY) begin
                            entry[entry_len] = key;
                            entry_len++;
                            ev = krlc_pkg::EV_DIGIT;
                        end else begin
                            entry_len = 0;
                            ev        = krlc_pkg::EV_OVERFLOW;
                        end
                    end else if (key == krlc_pkg::KEY_HASH) begin
                        ok = entry_ok();
                        if (sub == krlc_pkg::SUB_OLD) begin
                            sub = ok ? krlc_pkg::SUB_NEW : krlc_pkg::SUB_NORMAL;
                            ev  = ok ? krlc_pkg::EV_OLDOK : krlc_pkg::EV_OLDBAD;
                        end else if (sub == krlc_pkg::SUB_NEW) begin
                            pwd     = entry;
                            pwd_len = entry_len;
                            sub     = krlc_pkg::SUB_NORMAL;
                            ev      = krlc_pkg::EV_CHANGED;
                        end else if (ok) begin
                            grant = 1'b1;
                            ev    = krlc_pkg::EV_GRANT;
                        end else begin
                            ev = fail_event();
                        end
                        entry_len = 0;
                    end else if (key == krlc_pkg::KEY_STAR) begin
                        if (entry_len > 0) begin
                            entry_len--;
                            ev = krlc_pkg::EV_ERASE;
                        end
                    end else if (key == krlc_pkg::KEY_C) begin
                        sub       = krlc_pkg::SUB_OLD;
                        entry_len = 0;
                        ev        = krlc_pkg::EV_CHANGEREQ;
                    end else begin
                        ev = krlc_pkg::EV_IGNORED;
                    end
                end
            end else if (kind == krlc_pkg::KIND_CARD && mode == krlc_pkg::MODE_CARD) begin
                if (card == card_a || card == card_b) begin
                    grant = 1'b1;
                    ev    = krlc_pkg::EV_GRANT;
                end else begin
                    ev = fail_event();
                end
            end
            o.ev    = ev;
            o.grant = grant;
            o.lock  = locked;
            o.mode  = mode;
            o.count = 4'(entry_len);
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [3:0] ev, logic grant, logic lock,
                                    logic [1:0] md, logic [3:0] count);
            t_outcome e;
            if (pending_outcomes.size() == 0) begin
                $error("result transaction with no outstanding input");
                errors++;
                return;
            end
            e = pending_outcomes.pop_front();
            if (ev !== e.ev) begin
                $error("event_code: expected %0d, got %0d", e.ev, ev);
                errors++;
            end
            if (grant !== e.grant) begin
                $error("access_grant: expected %0d, got %0d", e.grant, grant);
                errors++;
            end
            if (lock !== e.lock) begin
                $error("locked_now: expected %0d, got %0d", e.lock, lock);
                errors++;
            end
            if (md !== e.mode) begin
                $error("current_mode: expected %0d, got %0d", e.mode, md);
                errors++;
            end
            if (count !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CARD_W-1:0] i_cfg_data;
    bit                src_gaps;
    bit                snk_gaps;
    int                items_sent;
    lock_tracker       sb;

    krlc_in_if #(.CARD_W(CARD_W)) in_if ();
    krlc_out_if                   out_if ();

    keypad_rfid_lock_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge i_clk) begin
        out_if.ready = !snk_gaps || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready)
            sb.check_outcome(out_if.event_code, out_if.access_grant, out_if.locked_now,
                             out_if.current_mode, out_if.entry_count);
    end

    function automatic logic [CARD_W-1:0] rand_card();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[CARD_W-1:0];
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [3:0] key,
                             input logic [CARD_W-1:0] card);
        @(negedge i_clk);
        while (src_gaps && $urandom_range(99) < 33) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    = 1'b1;
        in_if.kind     = kind;
        in_if.key_code = key;
        in_if.card_id  = card;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.note_transaction(kind, key, card);
        items_sent++;
    endtask

    task automatic send_key(input logic [3:0] key);
        send_item(krlc_pkg::KIND_KEY, key, rand_card());
    endtask

    task automatic send_card(input logic [CARD_W-1:0] card);
        send_item(krlc_pkg::KIND_CARD, 4'($urandom_range(15)), card);
    endtask

    task automatic send_tick();
        send_item(krlc_pkg::KIND_TICK, 4'($urandom_range(15)), rand_card());
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CARD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [CARD_W-1:0] card_a, input logic [CARD_W-1:0] card_b,
                              input logic [2:0] limit, input logic [15:0] ticks);
        hold_until_drained();
        write_reg(krlc_pkg::CFG_CARD_A, card_a);
        write_reg(krlc_pkg::CFG_CARD_B, card_b);
        write_reg(krlc_pkg::CFG_FAIL_LIMIT, CARD_W'(limit));
        write_reg(krlc_pkg::CFG_LOCK_TICKS, CARD_W'(ticks));
    endtask

    task automatic ride_out_lockout();
        while (sb.locked) begin
            if ($urandom_range(99) < 20)
                send_item(2'($urandom_range(1, 3)), 4'($urandom_range(15)), rand_card());
            else
                send_tick();
        end
    endtask

    task automatic goto_mode(input krlc_pkg::t_mode m);
        if (sb.mode != m) begin
            if (sb.mode != krlc_pkg::MODE_SELECT)
                send_key(krlc_pkg::KEY_D);
            send_key(m == krlc_pkg::MODE_KEYPAD ? krlc_pkg::KEY_A : krlc_pkg::KEY_B);
        end
    endtask

    task automatic type_password();
        for (int i = 0; i < sb.pwd_len; i++)
            send_key(sb.pwd[i]);
    endtask

    task automatic type_digits(input int n);
        repeat (n) send_key(4'($urandom_range(9)));
    endtask

    task automatic run_scenario();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (sb.locked)
            ride_out_lockout();
        if (pick < 30) begin
            goto_mode(krlc_pkg::MODE_KEYPAD);
            if ($urandom_range(99) < 55)
                type_password();
            else
                type_digits($urandom_range(10));
            if ($urandom_range(99) < 15) begin
                send_key(krlc_pkg::KEY_STAR);
                send_key(4'($urandom_range(9)));
            end
            send_key(krlc_pkg::KEY_HASH);
        end else if (pick < 50) begin
            goto_mode(krlc_pkg::MODE_CARD);
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       send_card(sb.card_a);
                    1:       send_card(sb.card_b);
                    2:       send_card(sb.card_a ^ (CARD_W'(1) << $urandom_range(CARD_W - 1)));
                    default: send_card(rand_card());
                endcase
            end
        end else if (pick < 65) begin
            goto_mode(krlc_pkg::MODE_KEYPAD);
            send_key(krlc_pkg::KEY_C);
            if ($urandom_range(99) < 75)
                type_password();
            else
                type_digits($urandom_range(10));
            send_key(krlc_pkg::KEY_HASH);
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, MAX_ENTRY);
            type_digits(n);
            send_key(krlc_pkg::KEY_HASH);
        end else if (pick < 72) begin
            goto_mode(krlc_pkg::MODE_KEYPAD);
            type_digits($urandom_range(10, 13));
            if ($urandom_range(1))
                send_key(krlc_pkg::KEY_HASH);
        end else if (pick < 80) begin
            send_key(4'($urandom_range(10, 15)));
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) send_tick();
        end else begin
            send_item(($urandom_range(9) == 0) ? KIND_SPARE : 2'($urandom_range(2)),
                      4'($urandom_range(15)), rand_card());
        end
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
            run_scenario();
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = krlc_pkg::CFG_CARD_A;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.kind     = krlc_pkg::KIND_TICK;
        in_if.key_code = 4'd0;
        in_if.card_id  = '0;
        out_if.ready   = 1'b0;
        src_gaps       = 1'b1;
        snk_gaps       = 1'b1;
        items_sent     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration
        send_item(KIND_SPARE, krlc_pkg::KEY_HASH, '1);
        send_key(4'd0);
        send_key(krlc_pkg::KEY_C);
        send_key(krlc_pkg::KEY_B);
        send_card(krlc_pkg::CARD_A_RESET[CARD_W-1:0]);
        send_card(krlc_pkg::CARD_B_RESET[CARD_W-1:0]);
        send_card('0);
        send_key(4'd7);
        send_key(krlc_pkg::KEY_D);
        send_card('1);
        send_key(krlc_pkg::KEY_A);
        send_key(krlc_pkg::KEY_STAR);
        send_key(krlc_pkg::KEY_A);
        send_key(krlc_pkg::KEY_B);
        type_password();
        send_key(krlc_pkg::KEY_HASH);
        send_key(krlc_pkg::KEY_DIGIT_MAX);
        send_key(4'd0);
        send_key(krlc_pkg::KEY_STAR);
        send_key(krlc_pkg::KEY_HASH);
        send_key(krlc_pkg::KEY_HASH);
        send_key(4'd5);
        send_card(krlc_pkg::CARD_A_RESET[CARD_W-1:0]);
        // still locked under the reset tick count, then shorten it mid-lockout
        repeat (40) send_tick();
        hold_until_drained();
        write_reg(krlc_pkg::CFG_LOCK_TICKS, CARD_W'(16'd50));
        ride_out_lockout();

        // overflow, then change to an empty password and back
        send_key(krlc_pkg::KEY_A);
        type_digits(MAX_ENTRY + 1);
        send_key(krlc_pkg::KEY_C);
        type_password();
        send_key(krlc_pkg::KEY_HASH);
        send_key(krlc_pkg::KEY_HASH);
        send_key(krlc_pkg::KEY_HASH);
        send_key(krlc_pkg::KEY_C);
        send_key(krlc_pkg::KEY_HASH);
        for (int i = 1; i <= krlc_pkg::PWD_RESET_LEN; i++)
            send_key(4'(i));
        send_key(krlc_pkg::KEY_HASH);

        set_config('0, '1, 3'd1, 16'd1);
        run_random(300);

        // full failure count and a long lockout with no gaps on either side
        set_config(rand_card(), rand_card(), krlc_pkg::FAIL_MAX, 16'd200);
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        if (sb.locked)
            ride_out_lockout();
        goto_mode(krlc_pkg::MODE_CARD);
        repeat (krlc_pkg::FAIL_MAX) send_card(rand_card());
        while (sb.locked)
            send_tick();
        src_gaps = 1'b1;
        snk_gaps = 1'b1;

        set_config(rand_card(), rand_card(), 3'd0, 16'd5);
        run_random(200);

        for (int p = 0; p < (ITEM_TARGET - 800) / 150; p++) begin
            logic [CARD_W-1:0] ca;
            ca = rand_card();
            set_config(ca, ($urandom_range(3) == 0) ? ca : rand_card(),
                       3'($urandom_range(1, 7)), 16'($urandom_range(1, 30)));
            run_random(150);
        end

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
